// ----- rtl/mff_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, constants and helper functions of the maze flood-fill engine.
package mff_pkg;

   localparam int MAZE_COLS   = 16;
   localparam int MAZE_ROWS   = 16;
   localparam int QUEUE_DEPTH = 256;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef logic [3:0] coord_type;
   typedef logic [7:0] cell_type;
   typedef logic [3:0] wall_type;
   typedef logic [7:0] dist_type;

   localparam dist_type  UNREACHABLE = 8'hFF;
   localparam coord_type CENTRE_LO   = 4'd7;
   localparam coord_type CENTRE_HI   = 4'd8;

   typedef enum logic [1:0] {
      DIR_N = 2'd0,
      DIR_E = 2'd1,
      DIR_S = 2'd2,
      DIR_W = 2'd3
   } dir_type;

   typedef enum logic [1:0] {
      CMD_SET_WALL  = 2'd0,
      CMD_RECALC    = 2'd1,
      CMD_BEST_MOVE = 2'd2,
      CMD_NONE      = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      CSR_TX_LO = 2'd0,
      CSR_TX_HI = 2'd1,
      CSR_TY_LO = 2'd2,
      CSR_TY_HI = 2'd3
   } csr_idx_type;

   typedef struct packed {
      logic     wall_we;
      cell_type wall_addr;
      wall_type wall_wdata;
      logic     dist_we;
      cell_type dist_addr;
      dist_type dist_wdata;
   } mem_cmd_type;

   typedef struct packed {
      logic     clear;
      logic     push;
      logic     pop;
      cell_type wdata;
   } q_cmd_type;

   typedef struct packed {
      logic empty;
      logic full;
   } q_stat_type;

   function automatic logic nb_in_maze(coord_type x, coord_type y, dir_type d);
      logic ok;
      unique case (d)
         DIR_N:   ok = (y != coord_type'(MAZE_ROWS - 1));
         DIR_E:   ok = (x != coord_type'(MAZE_COLS - 1));
         DIR_S:   ok = (y != coord_type'(0));
         default: ok = (x != coord_type'(0));
      endcase
      return ok;
   endfunction

   function automatic cell_type nb_cell(coord_type x, coord_type y, dir_type d);
      cell_type c;
      unique case (d)
         DIR_N:   c = {coord_type'(y + 4'd1), x};
         DIR_E:   c = {y, coord_type'(x + 4'd1)};
         DIR_S:   c = {coord_type'(y - 4'd1), x};
         default: c = {y, coord_type'(x - 4'd1)};
      endcase
      return c;
   endfunction

   function automatic dist_type axis_dist(coord_type c);
      dist_type d;
      if (c < CENTRE_LO) d = dist_type'(CENTRE_LO - c);
      else if (c > CENTRE_HI) d = dist_type'(c - CENTRE_HI);
      else d = '0;
      return d;
   endfunction

   function automatic dist_type init_dist(cell_type c);
      return dist_type'(axis_dist(c[3:0]) + axis_dist(c[7:4]));
   endfunction

   function automatic wall_type init_wall(cell_type c);
      wall_type w;
      w    = '0;
      w[0] = (c[7:4] == coord_type'(MAZE_ROWS - 1));
      w[1] = (c[3:0] == coord_type'(MAZE_COLS - 1));
      w[2] = (c[7:4] == coord_type'(0));
      w[3] = (c[3:0] == coord_type'(0));
      return w;
   endfunction

endpackage

// ----- rtl/mff_maze_mem.sv -----
`timescale 1ns / 1ps
// Wall and distance memories of the maze, one registered read port each.
module mff_maze_mem (
   input  logic                 clock,
   input  mff_pkg::mem_cmd_type mem_cmd,
   output mff_pkg::wall_type    wall_rdata_ff,
   output mff_pkg::dist_type    dist_rdata_ff
);
   import mff_pkg::*;

   wall_type wall_mem [MAZE_COLS*MAZE_ROWS];
   dist_type dist_mem [MAZE_COLS*MAZE_ROWS];

   always_ff @(posedge clock) begin
      if (mem_cmd.wall_we) begin
         wall_mem[mem_cmd.wall_addr] <= mem_cmd.wall_wdata;
      end
      wall_rdata_ff <= wall_mem[mem_cmd.wall_addr];
   end

   always_ff @(posedge clock) begin
      if (mem_cmd.dist_we) begin
         dist_mem[mem_cmd.dist_addr] <= mem_cmd.dist_wdata;
      end
      dist_rdata_ff <= dist_mem[mem_cmd.dist_addr];
   end

endmodule

// ----- rtl/mff_queue.sv -----
`timescale 1ns / 1ps
// Work queue of cells for the flood fill: FIFO memory with head, tail and count.
module mff_queue (
   input  logic                clock,
   input  logic                reset,
   input  mff_pkg::q_cmd_type  q_cmd,
   output mff_pkg::q_stat_type q_stat,
   output mff_pkg::cell_type   rdata_ff
);
   import mff_pkg::*;

   cell_type           q_mem [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  head_ff, head_in;
   logic [QPTR_W-1:0]  tail_ff, tail_in;
   logic [QCNT_W-1:0]  count_ff, count_in;
   logic               full;

   assign full         = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign q_stat.full  = full;
   assign q_stat.empty = (count_ff == '0);

   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      if (q_cmd.clear) begin
         head_in  = '0;
         tail_in  = '0;
         count_in = '0;
      end else if (q_cmd.push && !full) begin
         tail_in  = QPTR_W'(tail_ff + 1'b1);
         count_in = QCNT_W'(count_ff + 1'b1);
      end else if (q_cmd.pop && count_ff != '0) begin
         head_in  = QPTR_W'(head_ff + 1'b1);
         count_in = QCNT_W'(count_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_cmd.push && !full && !q_cmd.clear) begin
         q_mem[tail_ff] <= q_cmd.wdata;
      end
      if (q_cmd.pop) begin
         rdata_ff <= q_mem[head_ff];
      end
   end

endmodule

// ----- rtl/maze_floodfill_engine.sv -----
`timescale 1ns / 1ps
// Maze flood-fill engine: command sequencer with a shared neighbor scan unit.
// After reset an init sweep loads walls and distances of every cell; no word is taken.
// Set wall: updates the cell, then the neighbor cell if it lies in the maze. Best move: one memory read per cycle.
// Recalculate: a goal cell taken from the queue is skipped; any other is scanned
// through the single distance read port and, if relaxed, its open neighbors queued.
// One word in flight; the result register frees the input side once loaded.
module maze_floodfill_engine (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic [1:0]              req_cmd,
   input  mff_pkg::coord_type      req_cell_x,
   input  mff_pkg::coord_type      req_cell_y,
   input  logic [1:0]              req_direction,
   input  logic                    req_wall_present,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [1:0]              rsp_best_direction,
   output logic                    rsp_queue_overflow,
   input  logic                    csr_we,
   input  logic [1:0]              csr_index,
   input  logic [3:0]              csr_wdata
);
   import mff_pkg::*;

   typedef enum logic [13:0] {
      S_INIT   = 14'b00000000000001,
      S_IDLE   = 14'b00000000000010,
      S_SW_WR  = 14'b00000000000100,
      S_SW_NRD = 14'b00000000001000,
      S_SW_NWR = 14'b00000000010000,
      S_RC_ST  = 14'b00000000100000,
      S_RC_POP = 14'b00000001000000,
      S_RC_ENT = 14'b00000010000000,
      S_WALL   = 14'b00000100000000,
      S_SCAN   = 14'b00001000000000,
      S_UPD    = 14'b00010000000000,
      S_PUSH   = 14'b00100000000000,
      S_DONE   = 14'b01000000000000,
      S_SPARE  = 14'b10000000000000
   } state_type;

   state_type   state_ff, state_in;
   cmd_type     cmd_ff, cmd_in;
   coord_type   x_ff, x_in, y_ff, y_in;
   dir_type     dir_ff, dir_in;
   logic        present_ff, present_in;
   wall_type    walls_ff, walls_in;
   logic [2:0]  k_ff, k_in;
   dist_type    least_ff, least_in;
   dir_type     best_ff, best_in;
   logic        ovf_ff, ovf_in;
   cell_type    init_ff, init_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [1:0]  rsp_best_ff, rsp_best_in;
   logic        rsp_ovf_ff, rsp_ovf_in;
   coord_type   txl_ff, txh_ff, tyl_ff, tyh_ff;

   mem_cmd_type mem_cmd;
   wall_type    wall_rdata;
   dist_type    dist_rdata;
   q_cmd_type   q_cmd;
   q_stat_type  q_stat;
   cell_type    q_rdata;

   cell_type    cur_cell;
   dir_type     scan_d, push_d;
   logic        scan_open, push_open, ent_goal, relax;
   wall_type    dir_bit, opp_bit;
   dist_type    least_inc;

   mff_maze_mem u_mem (
      .clock         (clock),
      .mem_cmd       (mem_cmd),
      .wall_rdata_ff (wall_rdata),
      .dist_rdata_ff (dist_rdata)
   );

   mff_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .q_cmd    (q_cmd),
      .q_stat   (q_stat),
      .rdata_ff (q_rdata)
   );

   assign req_ready          = (state_ff == S_IDLE);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_best_direction = rsp_best_ff;
   assign rsp_queue_overflow = rsp_ovf_ff;

   assign cur_cell  = {y_ff, x_ff};
   assign scan_d    = dir_type'(2'(k_ff - 3'd1));
   assign push_d    = dir_type'(k_ff[1:0]);
   assign scan_open = !walls_ff[scan_d] && nb_in_maze(x_ff, y_ff, scan_d);
   assign push_open = !walls_ff[push_d] && nb_in_maze(x_ff, y_ff, push_d);
   assign dir_bit   = wall_type'(4'd1 << dir_ff);
   assign opp_bit   = wall_type'(4'd1 << 2'(dir_ff + 2'd2));
   assign least_inc = dist_type'(least_ff + 8'd1);
   assign relax     = (least_ff != UNREACHABLE) && (dist_rdata != least_inc);
   assign ent_goal  = (q_rdata[3:0] >= txl_ff) && (q_rdata[3:0] <= txh_ff) &&
                      (q_rdata[7:4] >= tyl_ff) && (q_rdata[7:4] <= tyh_ff);

   always_comb begin
      mem_cmd.wall_we    = 1'b0;
      mem_cmd.wall_addr  = cur_cell;
      mem_cmd.wall_wdata = wall_rdata;
      mem_cmd.dist_we    = 1'b0;
      mem_cmd.dist_addr  = cur_cell;
      mem_cmd.dist_wdata = least_inc;
      q_cmd.clear        = 1'b0;
      q_cmd.push         = 1'b0;
      q_cmd.pop          = 1'b0;
      q_cmd.wdata        = nb_cell(x_ff, y_ff, push_d);

      state_in     = state_ff;
      cmd_in       = cmd_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      dir_in       = dir_ff;
      present_in   = present_ff;
      walls_in     = walls_ff;
      k_in         = k_ff;
      least_in     = least_ff;
      best_in      = best_ff;
      ovf_in       = ovf_ff;
      init_in      = init_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_best_in  = rsp_best_ff;
      rsp_ovf_in   = rsp_ovf_ff;

      unique case (state_ff)
         S_INIT: begin
            mem_cmd.wall_we    = 1'b1;
            mem_cmd.wall_addr  = init_ff;
            mem_cmd.wall_wdata = init_wall(init_ff);
            mem_cmd.dist_we    = 1'b1;
            mem_cmd.dist_addr  = init_ff;
            mem_cmd.dist_wdata = init_dist(init_ff);
            init_in            = cell_type'(init_ff + 8'd1);
            if (init_ff == cell_type'(MAZE_COLS*MAZE_ROWS - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            mem_cmd.wall_addr = {req_cell_y, req_cell_x};
            if (req_valid) begin
               cmd_in     = cmd_type'(req_cmd);
               x_in       = req_cell_x;
               y_in       = req_cell_y;
               dir_in     = dir_type'(req_direction);
               present_in = req_wall_present;
               ovf_in     = 1'b0;
               unique case (cmd_type'(req_cmd))
                  CMD_SET_WALL:  state_in = S_SW_WR;
                  CMD_RECALC: begin
                     q_cmd.clear = 1'b1;
                     state_in    = S_RC_ST;
                  end
                  CMD_BEST_MOVE: state_in = S_WALL;
                  default:       state_in = S_DONE;
               endcase
            end
         end
         S_SW_WR: begin
            mem_cmd.wall_we    = 1'b1;
            mem_cmd.wall_wdata = present_ff ? (wall_rdata | dir_bit) : (wall_rdata & ~dir_bit);
            state_in = nb_in_maze(x_ff, y_ff, dir_ff) ? S_SW_NRD : S_DONE;
         end
         S_SW_NRD: begin
            mem_cmd.wall_addr = nb_cell(x_ff, y_ff, dir_ff);
            state_in          = S_SW_NWR;
         end
         S_SW_NWR: begin
            mem_cmd.wall_we    = 1'b1;
            mem_cmd.wall_addr  = nb_cell(x_ff, y_ff, dir_ff);
            mem_cmd.wall_wdata = present_ff ? (wall_rdata | opp_bit) : (wall_rdata & ~opp_bit);
            state_in           = S_DONE;
         end
         S_RC_ST: begin
            q_cmd.push  = 1'b1;
            q_cmd.wdata = cur_cell;
            state_in    = S_RC_POP;
         end
         S_RC_POP: begin
            if (q_stat.empty) begin
               state_in = S_DONE;
            end else begin
               q_cmd.pop = 1'b1;
               state_in  = S_RC_ENT;
            end
         end
         S_RC_ENT: begin
            mem_cmd.wall_addr = q_rdata;
            x_in              = q_rdata[3:0];
            y_in              = q_rdata[7:4];
            state_in          = ent_goal ? S_RC_POP : S_WALL;
         end
         S_WALL: begin
            walls_in = wall_rdata;
            k_in     = '0;
            least_in = UNREACHABLE;
            best_in  = dir_ff;
            state_in = S_SCAN;
         end
         S_SCAN: begin
            mem_cmd.dist_addr = (k_ff == 3'd4) ? cur_cell : nb_cell(x_ff, y_ff, push_d);
            if (k_ff != 3'd0 && scan_open) begin
               if (dist_rdata < least_ff) begin
                  least_in = dist_rdata;
                  best_in  = scan_d;
               end else if (dist_rdata == least_ff && scan_d == dir_ff) begin
                  best_in = scan_d;
               end
            end
            if (k_ff == 3'd4) begin
               state_in = (cmd_ff == CMD_RECALC) ? S_UPD : S_DONE;
            end else begin
               k_in = 3'(k_ff + 3'd1);
            end
         end
         S_UPD: begin
            k_in = '0;
            if (relax) begin
               mem_cmd.dist_we = 1'b1;
               state_in        = S_PUSH;
            end else begin
               state_in = S_RC_POP;
            end
         end
         S_PUSH: begin
            if (push_open) begin
               q_cmd.push = 1'b1;
               if (q_stat.full) begin
                  ovf_in = 1'b1;
               end
            end
            if (k_ff == 3'd3) begin
               state_in = S_RC_POP;
            end else begin
               k_in = 3'(k_ff + 3'd1);
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_best_in  = (cmd_ff == CMD_BEST_MOVE) ? best_ff : 2'd0;
               rsp_ovf_in   = (cmd_ff == CMD_RECALC) ? ovf_ff : 1'b0;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         init_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         init_ff      <= init_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      x_ff        <= x_in;
      y_ff        <= y_in;
      dir_ff      <= dir_in;
      present_ff  <= present_in;
      walls_ff    <= walls_in;
      k_ff        <= k_in;
      least_ff    <= least_in;
      best_ff     <= best_in;
      ovf_ff      <= ovf_in;
      rsp_best_ff <= rsp_best_in;
      rsp_ovf_ff  <= rsp_ovf_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         txl_ff <= CENTRE_LO;
         txh_ff <= CENTRE_HI;
         tyl_ff <= CENTRE_LO;
         tyh_ff <= CENTRE_HI;
      end else if (csr_we) begin
         unique case (csr_idx_type'(csr_index))
            CSR_TX_LO: txl_ff <= csr_wdata;
            CSR_TX_HI: txh_ff <= csr_wdata;
            CSR_TY_LO: tyl_ff <= csr_wdata;
            default:   tyh_ff <= csr_wdata;
         endcase
      end
   end

endmodule

// ----- rtl/mff_checker.sv -----
`timescale 1ns / 1ps
// Port-level checker of the maze flood-fill engine and its bind.
module mff_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [1:0] rsp_best_direction,
   input logic       rsp_queue_overflow
);

   a_init_busy: assert property (@(posedge clock) reset |=> !req_ready)
      else $error("word taken during init sweep");

   a_busy_after_take: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("second word taken while a command runs");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_best_direction)
                                     && $stable(rsp_queue_overflow)))
      else $error("stalled result word changed");

   a_rsp_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_queue_overflow && rsp_best_direction != 2'd0))
      else $error("overflow and move reported in one word");

endmodule

bind maze_floodfill_engine mff_checker u_mff_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_valid),
   .req_ready          (req_ready),
   .rsp_valid          (rsp_valid),
   .rsp_ready          (rsp_ready),
   .rsp_best_direction (rsp_best_direction),
   .rsp_queue_overflow (rsp_queue_overflow)
);

// ----- bench/testbench.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the maze flood-fill engine: directed and random traffic with a built-in predictor.
module testbench;
   import mff_pkg::*;

   localparam int HALF_PERIOD   = 6;
   localparam int IDLE_LIMIT    = 100000;
   localparam int FLOOD_BUDGET  = 2000;
   localparam int PHASE_WORDS   = 241;

   typedef struct {
      cmd_type    cmd;
      coord_type  x;
      coord_type  y;
      logic [1:0] dir;
      logic       wall;
   } maze_word_type;

   typedef struct {
      logic [1:0] move_dir;
      logic       overflow;
   } maze_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [1:0] req_cmd = '0;
   coord_type req_cell_x = '0;
   coord_type req_cell_y = '0;
   logic [1:0] req_direction = '0;
   logic req_wall_present = 1'b0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [1:0] rsp_best_direction;
   logic rsp_queue_overflow;
   logic csr_we = 1'b0;
   logic [1:0] csr_index = '0;
   logic [3:0] csr_wdata = '0;

   maze_floodfill_engine u_top (.*);

   always #HALF_PERIOD clock = ~clock;

   // predictor state
   wall_type  maze_wall[256];
   dist_type  maze_dist[256];
   logic [3:0] goal_xl, goal_xh, goal_yl, goal_yh;
   logic [7:0] flood_q[256];
   int flood_head, flood_tail, flood_cnt;
   bit flood_ovf;

   maze_word_type   pending_words[$];
   maze_result_type expected_results[$];
   int errors = 0;
   int cmd_seen[4] = '{0, 0, 0, 0};
   int overflow_seen = 0;
   int flood_skipped = 0;

   function automatic int cell_at(int x, int y);
      return y * 16 + x;
   endfunction

   function automatic bit side_open(int x, int y, int d);
      int nx, ny;
      nx = x + (d == DIR_E) - (d == DIR_W);
      ny = y + (d == DIR_N) - (d == DIR_S);
      if (nx < 0 || nx > 15 || ny < 0 || ny > 15) return 1'b0;
      return maze_wall[cell_at(x, y)][d] == 1'b0;
   endfunction

   function automatic int nb_of(int x, int y, int d);
      return cell_at(x + (d == DIR_E) - (d == DIR_W), y + (d == DIR_N) - (d == DIR_S));
   endfunction

   function automatic bit is_goal(int x, int y);
      return x >= goal_xl && x <= goal_xh && y >= goal_yl && y <= goal_yh;
   endfunction

   function automatic void flood_push(int c);
      if (flood_cnt >= 256) begin
         flood_ovf = 1'b1;
         return;
      end
      flood_q[flood_tail] = 8'(c);
      flood_tail = (flood_tail + 1) % 256;
      flood_cnt++;
   endfunction

   function automatic bit flood_recalc(int sx, int sy, output int pops);
      int cx, cy, least, d, c;
      flood_head = 0;
      flood_tail = 0;
      flood_cnt = 0;
      flood_ovf = 1'b0;
      pops = 0;
      flood_push(cell_at(sx, sy));
      while (flood_cnt != 0) begin
         c = flood_q[flood_head];
         cx = c % 16;
         cy = c / 16;
         flood_head = (flood_head + 1) % 256;
         flood_cnt--;
         pops++;
         if (!is_goal(cx, cy)) begin
            least = 255;
            for (d = 0; d < 4; d++)
               if (side_open(cx, cy, d) && maze_dist[nb_of(cx, cy, d)] < least)
                  least = maze_dist[nb_of(cx, cy, d)];
            if (least != 255 && maze_dist[c] != least + 1) begin
               maze_dist[c] = 8'(least + 1);
               for (d = 0; d < 4; d++)
                  if (side_open(cx, cy, d)) flood_push(nb_of(cx, cy, d));
            end
         end
      end
      return flood_ovf;
   endfunction

   function automatic logic [1:0] choose_move(int x, int y, int heading);
      int least, best, d, nb_dist;
      least = 255;
      best = heading;
      for (d = 0; d < 4; d++)
         if (side_open(x, y, d)) begin
            nb_dist = maze_dist[nb_of(x, y, d)];
            if (nb_dist < least) begin
               least = nb_dist;
               best = d;
            end else if (nb_dist == least && d == heading) begin
               best = d;
            end
         end
      return 2'(best);
   endfunction

   // predict one word and queue it; replace a recalc whose flood runs too long with a best move
   task automatic issue(cmd_type c, int x, int y, int d, bit w);
      maze_word_type word;
      maze_result_type res;
      dist_type saved[256];
      int pops, n;
      word = '{c, 4'(x), 4'(y), 2'(d), w};
      res = '{2'b00, 1'b0};
      case (c)
         CMD_SET_WALL: begin
            maze_wall[cell_at(x, y)][d] = w;
            n = x + (d == DIR_E) - (d == DIR_W);
            if (n >= 0 && n <= 15 && y + (d == DIR_N) - (d == DIR_S) >= 0 &&
                y + (d == DIR_N) - (d == DIR_S) <= 15)
               maze_wall[nb_of(x, y, d)][(d + 2) % 4] = w;
         end
         CMD_RECALC: begin
            saved = maze_dist;
            res.overflow = flood_recalc(x, y, pops);
            if (pops > FLOOD_BUDGET) begin
               maze_dist = saved;
               flood_skipped++;
               word.cmd = CMD_BEST_MOVE;
               res.overflow = 1'b0;
               res.move_dir = choose_move(x, y, d);
            end
         end
         CMD_BEST_MOVE: res.move_dir = choose_move(x, y, d);
         default: ;
      endcase
      cmd_seen[word.cmd]++;
      if (res.overflow) overflow_seen++;
      pending_words.push_back(word);
      expected_results.push_back(res);
   endtask

   task automatic write_goal(csr_idx_type idx, logic [3:0] val);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_TX_LO: goal_xl = val;
         CSR_TX_HI: goal_xh = val;
         CSR_TY_LO: goal_yl = val;
         default:   goal_yh = val;
      endcase
   endtask

   task automatic drain;
      wait (pending_words.size() == 0 && expected_results.size() == 0);
      @(posedge clock);
   endtask

   task automatic random_phase(int count);
      int k, x, y, d, j;
      k = 0;
      while (k < count) begin
         x = $urandom_range(0, 15);
         y = $urandom_range(0, 15);
         if ($urandom_range(0, 9) < 8) begin
            // explore step: sense walls, reflood, pick a move
            for (j = $urandom_range(0, 3); j > 0; j--) begin
               issue(CMD_SET_WALL, x, y, $urandom_range(0, 3), $urandom_range(0, 99) < 40);
               k++;
            end
            issue(CMD_RECALC, x, y, $urandom_range(0, 3), $urandom_range(0, 1));
            issue(CMD_BEST_MOVE, x, y, $urandom_range(0, 3), $urandom_range(0, 1));
            k += 2;
         end else begin
            issue(cmd_type'($urandom_range(0, 3)), x, y, $urandom_range(0, 3),
                  $urandom_range(0, 1));
            k++;
         end
      end
   endtask

   initial begin
      int p;
      logic [3:0] goals[8][4];
      goals = '{'{7, 8, 7, 8}, '{0, 15, 0, 15}, '{0, 0, 0, 0}, '{15, 15, 15, 15},
                '{0, 3, 12, 15}, '{9, 4, 7, 8}, '{5, 5, 10, 10}, '{7, 8, 7, 8}};
      for (int i = 0; i < 256; i++) begin
         maze_wall[i] = {(i % 16) == 0, (i / 16) == 0, (i % 16) == 15, (i / 16) == 15};
         maze_dist[i] = 8'(((i % 16) < 7 ? 7 - i % 16 : ((i % 16) > 8 ? i % 16 - 8 : 0)) +
                           ((i / 16) < 7 ? 7 - i / 16 : ((i / 16) > 8 ? i / 16 - 8 : 0)));
      end
      goal_xl = 7; goal_xh = 8; goal_yl = 7; goal_yh = 8;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      wait (req_ready === 1'b1);

      issue(CMD_BEST_MOVE, 0, 0, DIR_N, 0);
      issue(CMD_SET_WALL, 0, 0, DIR_S, 1);
      issue(CMD_SET_WALL, 0, 0, DIR_W, 0);
      issue(CMD_SET_WALL, 15, 15, DIR_N, 1);
      issue(CMD_SET_WALL, 15, 15, DIR_E, 0);
      for (int d = 0; d < 4; d++) issue(CMD_SET_WALL, 3, 3, d, 1);
      issue(CMD_BEST_MOVE, 3, 3, DIR_W, 1);
      issue(CMD_RECALC, 3, 3, DIR_N, 0);
      issue(CMD_SET_WALL, 3, 3, DIR_E, 0);
      issue(CMD_RECALC, 3, 3, DIR_E, 1);
      issue(CMD_NONE, 15, 15, DIR_W, 1);
      issue(CMD_RECALC, 0, 0, DIR_S, 0);
      issue(CMD_RECALC, 7, 7, DIR_N, 0);
      issue(CMD_SET_WALL, 7, 6, DIR_N, 1);
      issue(CMD_RECALC, 7, 6, DIR_N, 0);
      for (int d = 0; d < 4; d++) issue(CMD_BEST_MOVE, 7, 6, d, 0);
      issue(CMD_RECALC, 15, 15, DIR_W, 1);
      drain();

      for (p = 0; p < 8; p++) begin
         for (int r = 0; r < 4; r++) write_goal(csr_idx_type'(r), goals[p][r]);
         random_phase(PHASE_WORDS);
         drain();
      end
      repeat (30) @(posedge clock);
      $display("covered: set_wall %0d, recalc %0d, best_move %0d, idle cmd %0d words",
               cmd_seen[0], cmd_seen[1], cmd_seen[2], cmd_seen[3]);
      $display("goal settings 8, overflows %0d, long floods replaced %0d",
               overflow_seen, flood_skipped);
      if (errors == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   // sender: bursts with random gaps
   bit req_taken = 1'b0;
   int burst_left = 0;
   int gap_left = 0;

   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && !req_taken) begin
         req_valid <= 1'b1;
      end else if (gap_left > 0) begin
         req_valid <= 1'b0;
         gap_left <= gap_left - 1;
      end else if (pending_words.size() != 0) begin
         maze_word_type w;
         w = pending_words.pop_front();
         req_valid <= 1'b1;
         req_cmd <= w.cmd;
         req_cell_x <= w.x;
         req_cell_y <= w.y;
         req_direction <= w.dir;
         req_wall_present <= w.wall;
         if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 40);
            gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
         end else begin
            burst_left <= burst_left - 1;
         end
      end else begin
         req_valid <= 1'b0;
      end
   end

   // receiver: random stalls; pattern_cnt sets when their density is redrawn
   int ready_pct = 100;
   int pattern_cnt = 0;

   always @(negedge clock) begin
      pattern_cnt <= pattern_cnt + 1;
      if (pattern_cnt % 200 == 199) ready_pct <= ($urandom_range(0, 2) == 0) ? 100 :
                                                 $urandom_range(10, 90);
      rsp_ready <= ($urandom_range(0, 99) < ready_pct);
   end

   int idle_cycles = 0;

   always @(posedge clock) begin
      maze_result_type want;
      req_taken <= req_valid && req_ready;
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("%0t watchdog expired", $realtime);
         $display("status: fail");
         $finish;
      end else if (!reset && rsp_valid && rsp_ready) begin
         if (expected_results.size() == 0) begin
            $display("%0t unexpected result expected none actual dir %0d ovf %0d", $realtime,
                     rsp_best_direction, rsp_queue_overflow);
            errors++;
         end else begin
            want = expected_results.pop_front();
            if (rsp_best_direction !== want.move_dir) begin
               $display("%0t best_direction expected %0d actual %0d", $realtime,
                        want.move_dir, rsp_best_direction);
               errors++;
            end
            if (rsp_queue_overflow !== want.overflow) begin
               $display("%0t queue_overflow expected %0d actual %0d", $realtime,
                        want.overflow, rsp_queue_overflow);
               errors++;
            end
         end
      end
   end

endmodule
